FILE: src/yuyv_to_rgb24_stream_assert.svh
// Assertion macros for the YUYV to RGB stream block.
`ifndef YUYV_TO_RGB24_STREAM_ASSERT_SVH
`define YUYV_TO_RGB24_STREAM_ASSERT_SVH

`ifndef SYNTH
`define Y2R_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define Y2R_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  `Y2R_ASSERT(label, clk, rst_n, !(prop), msg)
`else
`define Y2R_ASSERT(label, clk, rst_n, prop, msg)
`define Y2R_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif

`endif

FILE: src/y2r_pkg.sv
package y2r_pkg;

  localparam logic [14:0] StrideCap = 15'd16384;
  localparam logic [12:0] HeightCap = 13'd4096;

  localparam logic [12:0] WidthReset  = 13'd640;
  localparam logic [12:0] HeightReset = 13'd480;
  localparam logic [14:0] StrideReset = 15'd1280;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_STRIDE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LANE_Y0 = 2'd0,
    LANE_U  = 2'd1,
    LANE_Y1 = 2'd2,
    LANE_V  = 2'd3
  } lane_e;

  typedef struct packed {
    logic [7:0] y0;
    logic [7:0] u;
    logic [7:0] y1;
    logic [7:0] v;
    logic       last;
  } group_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pair_last;
    logic       frame_end;
  } pixel_t;

  function automatic logic [7:0] clip8(input logic signed [10:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 11'sd255) begin
      res = 8'hFF;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

endpackage

FILE: src/y2r_fifo.sv
module y2r_fifo import y2r_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  // Depth is a power of two, at least 2
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = AddrW + 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = pop_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + AddrW'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + AddrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: src/y2r_front.sv
module y2r_front import y2r_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  output logic        grp_wr_o,
  output group_t      grp_o
);

  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [14:0] stride_q;

  logic [13:0] col_q, col_d;
  logic [11:0] row_q, row_d;
  logic [7:0]  y0_q, y0_d;
  logic [7:0]  u_q, u_d;
  logic [7:0]  y1_q, y1_d;

  logic [13:0] pixel_bytes;
  logic [14:0] two_w;
  logic [14:0] stride_raw;
  logic [14:0] stride_eff;
  logic [12:0] height_eff;
  logic [14:0] col_nx;
  logic [12:0] row_nx;
  logic        in_pix;
  logic        last;

  always_comb begin
    pixel_bytes = {width_q[12:1], 2'b00};
    two_w       = {1'b0, width_q, 1'b0};
    stride_raw  = (stride_q < two_w) ? two_w : stride_q;
    stride_eff  = (stride_raw > StrideCap) ? StrideCap : stride_raw;
    if (height_q == '0) begin
      height_eff = 13'd1;
    end else if (height_q > HeightCap) begin
      height_eff = HeightCap;
    end else begin
      height_eff = height_q;
    end
  end

  always_comb begin
    col_nx = {1'b0, col_q} + 15'd1;
    row_nx = {1'b0, row_q} + 13'd1;
    in_pix = (col_q < pixel_bytes);
    last   = (col_nx == {1'b0, pixel_bytes}) && (row_nx == height_eff);

    col_d = col_q;
    row_d = row_q;
    y0_d  = y0_q;
    u_d   = u_q;
    y1_d  = y1_q;
    grp_wr_o = 1'b0;

    if (accept_i) begin
      if (in_pix) begin
        unique case (lane_e'(col_q[1:0]))
          LANE_Y0: y0_d = data_byte_i;
          LANE_U:  u_d  = data_byte_i;
          LANE_Y1: y1_d = data_byte_i;
          LANE_V:  grp_wr_o = 1'b1;
          default: grp_wr_o = 1'b0;
        endcase
      end
      // a column at or past the stride (also after a register change) ends the line
      if (col_nx >= stride_eff) begin
        col_d = '0;
        row_d = (row_nx >= height_eff) ? '0 : row_nx[11:0];
      end else begin
        col_d = col_nx[13:0];
      end
    end
  end

  always_comb begin
    grp_o.y0   = y0_q;
    grp_o.u    = u_q;
    grp_o.y1   = y1_q;
    grp_o.v    = data_byte_i;
    grp_o.last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      stride_q <= StrideReset;
      col_q    <= '0;
      row_q    <= '0;
      y0_q     <= '0;
      u_q      <= '0;
      y1_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WIDTH:  width_q  <= cfg_data_i[12:0];
          CFG_HEIGHT: height_q <= cfg_data_i[12:0];
          CFG_STRIDE: stride_q <= cfg_data_i;
          default:    ;
        endcase
      end
      col_q <= col_d;
      row_q <= row_d;
      y0_q  <= y0_d;
      u_q   <= u_d;
      y1_q  <= y1_d;
    end
  end

endmodule

FILE: src/y2r_back.sv
module y2r_back import y2r_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   grp_empty_i,
  input  group_t grp_i,
  output logic   grp_pop_o,
  input  logic   pix_full_i,
  output logic   pix_wr_o,
  output pixel_t pix_o
);

  typedef struct packed {
    logic [7:0]        y0;
    logic [7:0]        y1;
    logic signed [9:0] u1;
    logic signed [8:0] rg;
    logic signed [8:0] v1;
    logic              last;
  } stage_t;

  stage_t stage_q, stage_d;
  logic   valid_q, valid_d;
  logic   sel_q, sel_d;

  logic signed [8:0]  du, dv;
  logic signed [15:0] pu, pu_sh;
  logic signed [11:0] rgs, rgs_sh;
  logic signed [10:0] v3, v3_sh;
  logic               done;
  logic [7:0]         y_sel;
  logic signed [10:0] y11;

  // chroma terms, registered once per group
  always_comb begin
    du     = $signed({1'b0, grp_i.u}) - 9'sd128;
    dv     = $signed({1'b0, grp_i.v}) - 9'sd128;
    pu     = (16'(du) <<< 7) + 16'(du);
    pu_sh  = pu >>> 6;
    rgs    = (12'(du) <<< 1) + 12'(du) + (12'(dv) <<< 2) + (12'(dv) <<< 1);
    rgs_sh = rgs >>> 3;
    v3     = (11'(dv) <<< 1) + 11'(dv);
    v3_sh  = v3 >>> 1;
  end

  always_comb begin
    pix_wr_o  = valid_q && !pix_full_i;
    done      = pix_wr_o && sel_q;
    grp_pop_o = !grp_empty_i && (!valid_q || done);

    stage_d = stage_q;
    valid_d = valid_q;
    sel_d   = sel_q;
    if (pix_wr_o) begin
      sel_d = !sel_q;
    end
    if (done) begin
      valid_d = 1'b0;
    end
    if (grp_pop_o) begin
      stage_d.y0   = grp_i.y0;
      stage_d.y1   = grp_i.y1;
      stage_d.u1   = pu_sh[9:0];
      stage_d.rg   = rgs_sh[8:0];
      stage_d.v1   = v3_sh[8:0];
      stage_d.last = grp_i.last;
      valid_d      = 1'b1;
      sel_d        = 1'b0;
    end
  end

  always_comb begin
    y_sel           = sel_q ? stage_q.y1 : stage_q.y0;
    y11             = $signed({3'b000, y_sel});
    pix_o.red       = clip8(y11 + 11'(stage_q.v1));
    pix_o.green     = clip8(y11 - 11'(stage_q.rg));
    pix_o.blue      = clip8(y11 + 11'(stage_q.u1));
    pix_o.pair_last = sel_q;
    pix_o.frame_end = sel_q && stage_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

endmodule

FILE: src/yuyv_to_rgb24_stream.sv
// A pixel pair passes from its V byte through the group queue, the back-end stage register and the pixel queue.
// Throughput: one byte per cycle sustained while full is low; each four-byte group gives two pixels.
// The back end converts one pixel per cycle while the pixel queue has room, so it keeps pace with the byte rate.
// full rises only when the group queue fills because results are not popped.
// Reset: registers return to 640 x 480 with stride 1280, the byte and line
// counters return to the start of a frame, and both queues come up empty.
`include "yuyv_to_rgb24_stream_assert.svh"

module yuyv_to_rgb24_stream import y2r_pkg::*; #(
  parameter int GroupDepth = 4,
  parameter int PixelDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        pair_last_o,
  output logic        frame_end_o
);

  logic   accept;
  logic   gq_wr, gq_full, gq_empty, gq_pop;
  group_t gq_wdata, gq_rdata;
  logic   px_wr, px_full;
  pixel_t px_wdata, px_rdata;

  assign accept = push && !full;
  assign full   = gq_full;

  y2r_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .grp_wr_o    (gq_wr),
    .grp_o       (gq_wdata)
  );

  y2r_fifo #(
    .Width ($bits(group_t)),
    .Depth (GroupDepth)
  ) u_group_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (gq_wr),
    .wr_data_i (gq_wdata),
    .full_o    (gq_full),
    .pop_i     (gq_pop),
    .rd_data_o (gq_rdata),
    .empty_o   (gq_empty)
  );

  y2r_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_empty_i (gq_empty),
    .grp_i       (gq_rdata),
    .grp_pop_o   (gq_pop),
    .pix_full_i  (px_full),
    .pix_wr_o    (px_wr),
    .pix_o       (px_wdata)
  );

  y2r_fifo #(
    .Width ($bits(pixel_t)),
    .Depth (PixelDepth)
  ) u_pixel_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (px_wr),
    .wr_data_i (px_wdata),
    .full_o    (px_full),
    .pop_i     (pop),
    .rd_data_o (px_rdata),
    .empty_o   (empty)
  );

  assign red_o       = px_rdata.red;
  assign green_o     = px_rdata.green;
  assign blue_o      = px_rdata.blue;
  assign pair_last_o = px_rdata.pair_last;
  assign frame_end_o = px_rdata.frame_end;

  `Y2R_ASSERT_NEVER(a_group_no_overflow, clk_i, rst_ni, gq_wr && gq_full, "group queue overflow")
  `Y2R_ASSERT_NEVER(a_pixel_no_overflow, clk_i, rst_ni, px_wr && px_full, "pixel queue overflow")
  `Y2R_ASSERT(a_group_lands, clk_i, rst_ni, (gq_wr && !gq_pop) |=> !gq_empty, "group item lost")
  `Y2R_ASSERT_NEVER(a_end_on_second, clk_i, rst_ni, !empty && frame_end_o && !pair_last_o, "frame end on first pixel")

endmodule

FILE: verif/tb_top.sv
import y2r_pkg::*;

// Holds the converter's expected pixels and a running copy of its byte/line position.
class pixel_board;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [14:0] stride_q;
  int unsigned col_q;
  int unsigned row_q;
  logic [7:0]  y0_q;
  logic [7:0]  u_q;
  logic [7:0]  y1_q;
  pixel_t      due_q[$];
  int          errors;

  function new();
    width_q  = WidthReset;
    height_q = HeightReset;
    stride_q = StrideReset;
    col_q    = 0;
    row_q    = 0;
    y0_q     = '0;
    u_q      = '0;
    y1_q     = '0;
    errors   = 0;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [14:0] val);
    case (idx)
      CFG_WIDTH:  width_q  = val[12:0];
      CFG_HEIGHT: height_q = val[12:0];
      CFG_STRIDE: stride_q = val;
      default: ;
    endcase
  endfunction

  function int pending();
    return due_q.size();
  endfunction

  function logic [7:0] sat8(int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  // One accepted item: a V byte inside the pixel area yields a pixel pair.
  function void note_byte(logic [7:0] b);
    int unsigned pix_bytes;
    int unsigned eff_stride;
    int unsigned eff_height;
    int unsigned col;
    int          du;
    int          dv;
    int          u_off;
    int          g_off;
    int          v_off;
    pixel_t      p0;
    pixel_t      p1;
    pix_bytes  = 32'(width_q >> 1) * 4;
    eff_stride = 32'(stride_q);
    if (eff_stride < 2 * 32'(width_q)) eff_stride = 2 * 32'(width_q);
    if (eff_stride > 32'(StrideCap)) eff_stride = 32'(StrideCap);
    eff_height = 32'(height_q);
    if (eff_height == 0) eff_height = 1;
    if (eff_height > 32'(HeightCap)) eff_height = 32'(HeightCap);
    col = col_q;
    if (col < pix_bytes) begin
      case (lane_e'(col[1:0]))
        LANE_Y0: y0_q = b;
        LANE_U:  u_q  = b;
        LANE_Y1: y1_q = b;
        default: begin
          du    = int'(u_q) - 128;
          dv    = int'(b) - 128;
          u_off = (129 * du) >>> 6;
          g_off = (3 * du + 6 * dv) >>> 3;
          v_off = (3 * dv) >>> 1;
          p0.red       = sat8(int'(y0_q) + v_off);
          p0.green     = sat8(int'(y0_q) - g_off);
          p0.blue      = sat8(int'(y0_q) + u_off);
          p0.pair_last = 1'b0;
          p0.frame_end = 1'b0;
          p1.red       = sat8(int'(y1_q) + v_off);
          p1.green     = sat8(int'(y1_q) - g_off);
          p1.blue      = sat8(int'(y1_q) + u_off);
          p1.pair_last = 1'b1;
          p1.frame_end = (col + 1 == pix_bytes) && (row_q + 1 == eff_height);
          due_q.push_back(p0);
          due_q.push_back(p1);
        end
      endcase
    end
    col++;
    if (col >= eff_stride) begin
      col = 0;
      row_q++;
      if (row_q >= eff_height) row_q = 0;
    end
    col_q = col & 32'h3FFF;
    row_q = row_q & 32'hFFF;
  endfunction

  task report(string what);
    $display("ERROR @%0t: %s", $time, what);
    errors++;
  endtask

  task check(pixel_t got);
    pixel_t want;
    if (due_q.size() == 0) begin
      report("pixel popped with none expected");
      return;
    end
    want = due_q.pop_front();
    if (got.red !== want.red)
      report($sformatf("red got %0d want %0d", got.red, want.red));
    if (got.green !== want.green)
      report($sformatf("green got %0d want %0d", got.green, want.green));
    if (got.blue !== want.blue)
      report($sformatf("blue got %0d want %0d", got.blue, want.blue));
    if (got.pair_last !== want.pair_last)
      report($sformatf("pair_last got %b want %b", got.pair_last, want.pair_last));
    if (got.frame_end !== want.frame_end)
      report($sformatf("frame_end got %b want %b", got.frame_end, want.frame_end));
  endtask
endclass

module tb_top;
  localparam int LongHold   = 100;
  localparam int CycleLimit = 400000;

  typedef struct {
    int w;
    int h;
    int s;
    int n;
    bit calm;
  } phase_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [14:0] cfg_data_i  = '0;
  logic        push        = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        pop         = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic        pair_last_o;
  logic        frame_end_o;

  pixel_board  board = new();
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;

  always #10 clk_i = ~clk_i;

  yuyv_to_rgb24_stream dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .empty       (empty),
    .pop         (pop),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .pair_last_o (pair_last_o),
    .frame_end_o (frame_end_o)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // bias toward extremes and mid-scale chroma so clipping hits both rails
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(120, 136));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (full);
    board.note_byte(b);
  endtask

  task automatic settle();
    while (board.pending() != 0) @(posedge clk_i);
    // trailing padding items give no pixel; let them drain too
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(int w, int h, int s);
    logic [14:0] wv;
    logic [14:0] hv;
    logic [14:0] sv;
    // bits above the 13-bit registers are junk and must be dropped
    wv = 15'(w) | (15'($urandom_range(0, 3)) << 13);
    hv = 15'(h) | (15'($urandom_range(0, 3)) << 13);
    sv = 15'(s);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WIDTH;
    cfg_data_i <= wv;
    @(posedge clk_i);
    board.set_reg(CFG_WIDTH, wv);
    cfg_idx_i  <= CFG_HEIGHT;
    cfg_data_i <= hv;
    @(posedge clk_i);
    board.set_reg(CFG_HEIGHT, hv);
    cfg_idx_i  <= CFG_STRIDE;
    cfg_data_i <= sv;
    @(posedge clk_i);
    board.set_reg(CFG_STRIDE, sv);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_bytes(int n, bit pause_mid);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        push <= 1'b0;
        @(posedge clk_i);
        while (board.pending() != 0) @(posedge clk_i);
      end
      send_byte(pick_byte());
    end
    push <= 1'b0;
    settle();
  endtask

  initial begin
    pixel_t got;
    wait (rst_ni);
    forever begin
      int gap;
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        gap = gap_len();
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.red       = red_o;
      got.green     = green_o;
      got.blue      = blue_o;
      got.pair_last = pair_last_o;
      got.frame_end = frame_end_o;
      board.check(got);
    end
  end

  initial begin
    phase_t plan[$];
    logic [7:0] directed[$];
    plan.push_back('{4, 3, 8, 150, 1'b0});
    plan.push_back('{2, 1, 4, 100, 1'b1});          // smallest frame
    plan.push_back('{6, 2, 2, 120, 1'b1});          // short stride, long receiver hold
    plan.push_back('{5, 3, 14, 150, 1'b0});         // odd width plus padding
    plan.push_back('{0, 0, 0, 30, 1'b0});           // all zero: nothing comes out
    plan.push_back('{1, 5, 6, 20, 1'b0});           // width below two
    plan.push_back('{8, 8191, 16, 120, 1'b0});      // height beyond cap
    plan.push_back('{8191, 4096, 32767, 150, 1'b0}); // width and stride with every bit set, height at the cap
    plan.push_back('{3, 0, 6, 100, 1'b1});          // height zero acts as one line
    // odd width, one pixel pair per line, padding; rails and mid-scale
    directed = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd11, 8'd22, 8'd33, 8'd44,
                 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd1,
                 8'd128, 8'd128, 8'd128, 8'd128, 8'd5, 8'd6, 8'd7, 8'd8};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values first
    run_bytes(40, 1'b0);

    write_regs(3, 2, 8);
    foreach (directed[i]) send_byte(directed[i]);
    push <= 1'b0;
    settle();

    foreach (plan[k]) begin
      write_regs(plan[k].w, plan[k].h, plan[k].s);
      calm = plan[k].calm;
      if (k == 2) hold_off_req = 1'b1;
      run_bytes(plan[k].n, k == 3);
    end

    calm = 1'b0;
    repeat (3) begin
      write_regs($urandom_range(2, 12), $urandom_range(0, 4), $urandom_range(0, 40));
      run_bytes(60, 1'b0);
    end

    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
